// ===== rtl/gnoise_pkg.sv =====
// ----------------------------------------------------------------------------
// gnoise_pkg
// Shared constants for the 3D gradient noise block: default sizes, port
// widths, command codes and configuration register indexes.
// ----------------------------------------------------------------------------
package gnoise_pkg;

  // Default sizes of the permutation table and of the coordinate fraction.
  localparam int TABLE_ENTRIES = 256;
  localparam int FRAC_BITS     = 16;

  // Fixed port widths.
  localparam int POS_W     = 32;
  localparam int OFS_W     = 24;
  localparam int ENTRY_W   = 8;
  localparam int NOISE_W   = 19;
  localparam int CFG_IDX_W = 2;

  // Largest magnitude of the noise result, 2.0 in Q2.16.
  localparam int NOISE_MAX = 131072;

  // Commands carried by an input beat.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z = 2'd2;

endpackage

// ===== rtl/gnoise_ram.sv =====
// ----------------------------------------------------------------------------
// gnoise_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gnoise_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports; the data holds while re is low.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

// ===== rtl/gnoise_fade.sv =====
// ----------------------------------------------------------------------------
// gnoise_fade
// Three-stage quintic fade curve 6t^5 - 15t^4 + 10t^3 on an unsigned
// fraction, each product rounded to nearest and the result capped at 1.0.
// ----------------------------------------------------------------------------
module gnoise_fade #(
  parameter int FRAC_BITS = gnoise_pkg::FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [FRAC_BITS-1:0] t,
  output logic [FRAC_BITS:0]   fade
);

  localparam int F   = FRAC_BITS;
  localparam int QW  = F + 5;
  localparam int P1W = 2 * F + 1;
  localparam int P3W = 2 * F + 6;
  localparam logic [P3W-1:0] HALF = P3W'(1) << (F - 1);
  localparam logic [QW-1:0]  ONE_Q = QW'(1) << F;

  logic [P1W-1:0] sq;
  logic [P1W-1:0] cube;
  logic [QW-1:0]  q_next;
  logic [P3W-1:0] prod;
  logic [P3W-1:0] prod_shr;

  logic [F-1:0]  t_a;
  logic [F:0]    t2;
  logic [F:0]    t3;
  logic [QW-1:0] q;

  // Stage a: t squared.
  assign sq = P1W'(t) * P1W'(t) + P1W'(HALF);

  // Stage b: t cubed and the quadratic factor.
  assign cube   = P1W'(t2) * P1W'(t_a) + P1W'(HALF);
  assign q_next = QW'(6) * QW'(t2) + QW'(10) * ONE_Q - QW'(15) * QW'(t_a);

  // Stage c: final product and cap.
  assign prod     = P3W'(t3) * P3W'(q) + HALF;
  assign prod_shr = prod >> F;

  always_ff @(posedge clk) begin
    if (en) begin
      t_a <= t;
      t2  <= sq[2*F:F];
      t3  <= cube[2*F:F];
      q   <= q_next;
      if (prod_shr > P3W'(ONE_Q)) begin
        fade <= ONE_Q[F:0];
      end else begin
        fade <= prod_shr[F:0];
      end
    end
  end

endmodule

// ===== rtl/gnoise_lerp.sv =====
// ----------------------------------------------------------------------------
// gnoise_lerp
// Two-stage linear blend a + round(t * (b - a)), rounding ties away from
// zero on the magnitude of the product.
// ----------------------------------------------------------------------------
module gnoise_lerp #(
  parameter int FRAC_BITS = gnoise_pkg::FRAC_BITS,
  parameter int WIDTH     = gnoise_pkg::FRAC_BITS + 3
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [FRAC_BITS:0]      t,
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output logic signed [WIDTH-1:0] y
);

  localparam int F  = FRAC_BITS;
  localparam int PW = WIDTH + F + 2;
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  logic signed [WIDTH:0] diff;
  logic [WIDTH:0]        mag;
  logic [PW-1:0]         prod;
  logic [PW-1:0]         rnd;
  logic signed [WIDTH:0] part;
  logic signed [WIDTH:0] sum;

  logic [PW-1:0]           prod_r;
  logic                    neg_r;
  logic signed [WIDTH-1:0] a_r;

  // Stage a: difference magnitude times the weight.
  assign diff = (WIDTH+1)'(b) - (WIDTH+1)'(a);
  assign mag  = diff[WIDTH] ? -diff : diff;
  assign prod = PW'(mag) * PW'(t);

  // Stage b: round, restore sign and add the base.
  assign rnd  = (prod_r + HALF) >> F;
  assign part = signed'(rnd[WIDTH:0]);
  assign sum  = neg_r ? (WIDTH+1)'(a_r) - part : (WIDTH+1)'(a_r) + part;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      neg_r  <= diff[WIDTH];
      a_r    <= a;
      y      <= sum[WIDTH-1:0];
    end
  end

endmodule

// ===== rtl/gradient_noise_3d.sv =====
// ----------------------------------------------------------------------------
// gradient_noise_3d
// Fixed-point 3D improved gradient noise. Load beats fill the permutation
// table; evaluate beats return one signed Q2.16 noise value each.
//
//   channel  signals                                     direction
//   in       in_valid/in_ready, command, pos_*, entry_*  into block
//   out      out_valid/out_ready, noise_value            out of block
//   cfg      cfg_write, cfg_index, cfg_data              into block
//
// Evaluate beats flow through a 12-stage pipeline, one per cycle when not stalled;
// valid bits pass through v[1] to v[11] into out_valid. The three hash levels read
// seven copies of the table, each with two read ports, so no lookup waits.
// A load beat is taken only when no evaluate beat is in the three hash stages.
// A stall on out_ready freezes every stage; reset clears all valid bits and
// the offsets, while the table holds no reset value and must be loaded.
// ----------------------------------------------------------------------------
module gradient_noise_3d #(
  parameter int TABLE_ENTRIES = gnoise_pkg::TABLE_ENTRIES,
  parameter int FRAC_BITS     = gnoise_pkg::FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                command,
  input  logic signed [gnoise_pkg::POS_W-1:0] pos_x,
  input  logic signed [gnoise_pkg::POS_W-1:0] pos_y,
  input  logic signed [gnoise_pkg::POS_W-1:0] pos_z,
  input  logic [gnoise_pkg::ENTRY_W-1:0]      entry_index,
  input  logic [gnoise_pkg::ENTRY_W-1:0]      entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [gnoise_pkg::NOISE_W-1:0] noise_value,
  input  logic                                cfg_write,
  input  logic [gnoise_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gnoise_pkg::OFS_W-1:0]        cfg_data
);

  localparam int F      = FRAC_BITS;
  localparam int IW     = $clog2(TABLE_ENTRIES);
  localparam int EW     = gnoise_pkg::ENTRY_W;
  localparam int SW     = (F + IW > gnoise_pkg::POS_W + 1) ? F + IW : gnoise_pkg::POS_W + 1;
  localparam int LW     = F + 3;
  localparam int CW     = LW + 16;
  localparam int NRAM   = 7;
  localparam int NSTAGE = 11;
  localparam int SH_DN  = (F > 16) ? F - 16 : 0;
  localparam int SH_UP  = (F < 16) ? 16 - F : 0;
  localparam int HALF_DN = (1 << SH_DN) >> 1;
  localparam logic signed [LW-1:0] ONE_L = LW'(1) << F;
  localparam logic signed [CW-1:0] MAX_C = CW'(gnoise_pkg::NOISE_MAX);

  // Gradient dot product for one of twelve directions.
  function automatic logic signed [LW-1:0] grad(input logic [3:0] k,
                                                input logic signed [LW-1:0] x,
                                                input logic signed [LW-1:0] y,
                                                input logic signed [LW-1:0] z);
    logic signed [LW-1:0] ga;
    logic signed [LW-1:0] gb;
    ga = (k < 4'd8) ? x : y;
    if (k < 4'd4) begin
      gb = y;
    end else if (k == 4'd12 || k == 4'd14) begin
      gb = x;
    end else begin
      gb = z;
    end
    return (k[0] ? -ga : ga) + (k[1] ? -gb : gb);
  endfunction

  // Configuration registers.
  logic [gnoise_pkg::OFS_W-1:0] offset_x;
  logic [gnoise_pkg::OFS_W-1:0] offset_y;
  logic [gnoise_pkg::OFS_W-1:0] offset_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gnoise_pkg::CFG_OFFSET_X: offset_x <= cfg_data;
        gnoise_pkg::CFG_OFFSET_Y: offset_y <= cfg_data;
        gnoise_pkg::CFG_OFFSET_Z: offset_z <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake and pipeline advance.
  logic              adv;
  logic              accept;
  logic              load_we;
  logic [NSTAGE:1]   v;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && (command == gnoise_pkg::CMD_EVAL || !(|v[3:1]));
  assign accept   = in_valid && in_ready;
  assign load_we  = accept && command == gnoise_pkg::CMD_LOAD;

  always_ff @(posedge clk) begin
    if (rst) begin
      v         <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v         <= {v[NSTAGE-1:1], accept && command == gnoise_pkg::CMD_EVAL};
      out_valid <= v[NSTAGE];
    end
  end

  // Coordinate split into lattice cell and fraction.
  logic [SW-1:0] sum_x;
  logic [SW-1:0] sum_y;
  logic [SW-1:0] sum_z;

  assign sum_x = SW'(pos_x) + SW'(offset_x);
  assign sum_y = SW'(pos_y) + SW'(offset_y);
  assign sum_z = SW'(pos_z) + SW'(offset_z);

  logic [IW-1:0] ix1, iy1, iz1, iy2, iz2, iz3;
  logic [F-1:0]  fx1, fy1, fz1, fx2, fy2, fz2, fx3, fy3, fz3, fx4, fy4, fz4;

  always_ff @(posedge clk) begin
    if (adv) begin
      ix1 <= sum_x[F+IW-1:F];
      iy1 <= sum_y[F+IW-1:F];
      iz1 <= sum_z[F+IW-1:F];
      fx1 <= sum_x[F-1:0];
      fy1 <= sum_y[F-1:0];
      fz1 <= sum_z[F-1:0];
      iy2 <= iy1;
      iz2 <= iz1;
      iz3 <= iz2;
      fx2 <= fx1;
      fy2 <= fy1;
      fz2 <= fz1;
      fx3 <= fx2;
      fy3 <= fy2;
      fz3 <= fz2;
      fx4 <= fx3;
      fy4 <= fy3;
      fz4 <= fz3;
    end
  end

  // Fade weights, ready in stage 4.
  logic [F:0] u4, v4, w4;

  gnoise_fade #(.FRAC_BITS(F)) u_fade_x (.clk(clk), .en(adv), .t(fx1), .fade(u4));
  gnoise_fade #(.FRAC_BITS(F)) u_fade_y (.clk(clk), .en(adv), .t(fy1), .fade(v4));
  gnoise_fade #(.FRAC_BITS(F)) u_fade_z (.clk(clk), .en(adv), .t(fz1), .fade(w4));

  // Permutation table copies, one per lookup pair of the hash levels.
  logic [IW-1:0] raddr [NRAM][2];
  logic [EW-1:0] rd    [NRAM][2];
  logic [IW-1:0] ha, hb, haa, hab, hba, hbb;

  assign ha  = IW'(rd[0][0]) + iy2;
  assign hb  = IW'(rd[0][1]) + iy2;
  assign haa = IW'(rd[1][0]) + iz3;
  assign hab = IW'(rd[1][1]) + iz3;
  assign hba = IW'(rd[2][0]) + iz3;
  assign hbb = IW'(rd[2][1]) + iz3;

  always_comb begin
    raddr[0][0] = ix1;
    raddr[0][1] = ix1 + IW'(1);
    raddr[1][0] = ha;
    raddr[1][1] = ha + IW'(1);
    raddr[2][0] = hb;
    raddr[2][1] = hb + IW'(1);
    raddr[3][0] = haa;
    raddr[3][1] = haa + IW'(1);
    raddr[4][0] = hab;
    raddr[4][1] = hab + IW'(1);
    raddr[5][0] = hba;
    raddr[5][1] = hba + IW'(1);
    raddr[6][0] = hbb;
    raddr[6][1] = hbb + IW'(1);
  end

  for (genvar gi = 0; gi < NRAM; gi++) begin : g_table
    gnoise_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
      .clk   (clk),
      .we    (load_we),
      .waddr (IW'(entry_index)),
      .wdata (entry_value),
      .re    (adv),
      .raddr0(raddr[gi][0]),
      .raddr1(raddr[gi][1]),
      .rdata0(rd[gi][0]),
      .rdata1(rd[gi][1])
    );
  end

  // Corner gradients in stage 4, registered into stage 5.
  logic signed [LW-1:0] x0, x1, y0, y1, z0, z1;
  logic signed [LW-1:0] ga [4];
  logic signed [LW-1:0] gb [4];
  logic signed [LW-1:0] ga5 [4];
  logic signed [LW-1:0] gb5 [4];
  logic [F:0] u5, v5, w5, v6, w6, v7, w7, w8, w9;

  assign x0 = LW'(fx4);
  assign y0 = LW'(fy4);
  assign z0 = LW'(fz4);
  assign x1 = x0 - ONE_L;
  assign y1 = y0 - ONE_L;
  assign z1 = z0 - ONE_L;

  always_comb begin
    ga[0] = grad(rd[3][0][3:0], x0, y0, z0);
    gb[0] = grad(rd[5][0][3:0], x1, y0, z0);
    ga[1] = grad(rd[4][0][3:0], x0, y1, z0);
    gb[1] = grad(rd[6][0][3:0], x1, y1, z0);
    ga[2] = grad(rd[3][1][3:0], x0, y0, z1);
    gb[2] = grad(rd[5][1][3:0], x1, y0, z1);
    ga[3] = grad(rd[4][1][3:0], x0, y1, z1);
    gb[3] = grad(rd[6][1][3:0], x1, y1, z1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ga5 <= ga;
      gb5 <= gb;
      u5  <= u4;
      v5  <= v4;
      w5  <= w4;
      v6  <= v5;
      w6  <= w5;
      v7  <= v6;
      w7  <= w6;
      w8  <= w7;
      w9  <= w8;
    end
  end

  // Trilinear blend: x along each x edge of the cell, then y, then z.
  logic signed [LW-1:0] lx [4];
  logic signed [LW-1:0] ly [2];
  logic signed [LW-1:0] lz;

  for (genvar gi = 0; gi < 4; gi++) begin : g_lerp_x
    gnoise_lerp #(.FRAC_BITS(F), .WIDTH(LW)) u_lerp (
      .clk(clk), .en(adv), .t(u5), .a(ga5[gi]), .b(gb5[gi]), .y(lx[gi])
    );
  end

  for (genvar gi = 0; gi < 2; gi++) begin : g_lerp_y
    gnoise_lerp #(.FRAC_BITS(F), .WIDTH(LW)) u_lerp (
      .clk(clk), .en(adv), .t(v7), .a(lx[2*gi]), .b(lx[2*gi+1]), .y(ly[gi])
    );
  end

  gnoise_lerp #(.FRAC_BITS(F), .WIDTH(LW)) u_lerp_z (
    .clk(clk), .en(adv), .t(w9), .a(ly[0]), .b(ly[1]), .y(lz)
  );

  // Rescale to 16 fraction bits and clamp.
  logic [LW-1:0]        lz_mag;
  logic [CW-1:0]        rnd;
  logic signed [CW-1:0] conv;
  logic signed [CW-1:0] clamped;

  assign lz_mag = lz[LW-1] ? -lz : lz;

  always_comb begin
    rnd = (CW'(lz_mag) + CW'(HALF_DN)) >> SH_DN;
    if (F > 16) begin
      conv = lz[LW-1] ? -signed'(rnd) : signed'(rnd);
    end else begin
      conv = CW'(lz) <<< SH_UP;
    end
    if (conv > MAX_C) begin
      clamped = MAX_C;
    end else if (conv < -MAX_C) begin
      clamped = -MAX_C;
    end else begin
      clamped = conv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      noise_value <= clamped[gnoise_pkg::NOISE_W-1:0];
    end
  end

endmodule
